// ===== rtl/dtfx_pkg.sv =====
// Shared types and constants for the decimal text to fixed-point converter.
// Used by dtfx_char_step, decimal_text_to_fixed_point and the bench; no dependencies.
`default_nettype none

package dtfx_pkg;

	localparam int FRAC_BITS       = 32;
	localparam int MAX_FRAC_DIGITS = 10;
	localparam int INT_W           = 31;
	localparam int DIGIT_CNT_W     = 4;
	localparam int VALUE_W         = 64;

	localparam logic [INT_W-1:0] INT_MAX = {INT_W{1'b1}};

	// parse phases
	localparam logic [1:0] PH_SKIP = 2'd0;
	localparam logic [1:0] PH_INT  = 2'd1;
	localparam logic [1:0] PH_FRAC = 2'd2;
	localparam logic [1:0] PH_DONE = 2'd3;

	// characters of interest
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_MINUS = 8'h2d;
	localparam logic [7:0] CH_PLUS  = 8'h2b;
	localparam logic [7:0] CH_POINT = 8'h2e;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	// floor(2^FRAC_BITS / 10^k), entry k-1 for fraction digit k
	localparam logic [FRAC_BITS-1:0] FRAC_WEIGHT [10] = '{
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd10),
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd100),
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd1000),
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd10000),
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd100000),
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd1000000),
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd10000000),
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd100000000),
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd1000000000),
		FRAC_BITS'((64'd1 << FRAC_BITS) / 64'd10000000000)
	};

	typedef struct packed {
		logic [1:0]             phase;
		logic                   negative;
		logic [INT_W-1:0]       int_acc;
		logic [FRAC_BITS-1:0]   frac_acc;
		logic [DIGIT_CNT_W-1:0] frac_digits;
		logic                   saturated;
	} parse_state_t;

	localparam parse_state_t PARSE_CLEAR = '{
		phase:       PH_SKIP,
		negative:    1'b0,
		int_acc:     '0,
		frac_acc:    '0,
		frac_digits: '0,
		saturated:   1'b0
	};

endpackage

`default_nettype wire

// ===== rtl/dtfx_char_step.sv =====
// Next-state logic of the parser for one character.
// Depends on dtfx_pkg.
`default_nettype none

module dtfx_char_step
	import dtfx_pkg::*;
(
	input  wire logic [7:0]   ch,
	input  wire parse_state_t cur,
	output parse_state_t      nxt
);

	logic                   is_digit;
	logic [3:0]             d;
	logic                   go_on;
	logic [1:0]             phase_eff;
	logic [INT_W+3:0]       int_t;
	logic [FRAC_BITS+3:0]   frac_term;
	logic [FRAC_BITS-1:0]   weight;

	always_comb begin
		is_digit  = ch inside {[CH_ZERO:CH_NINE]};
		d         = is_digit ? 4'(ch - CH_ZERO) : 4'd0;
		int_t     = (INT_W+4)'(cur.int_acc) * (INT_W+4)'(10) + (INT_W+4)'(d);
		weight    = FRAC_WEIGHT[cur.frac_digits];
		frac_term = (FRAC_BITS+4)'(d) * (FRAC_BITS+4)'(weight);

		nxt       = cur;
		go_on     = 1'b1;
		phase_eff = cur.phase;

		if (cur.phase == PH_SKIP) begin
			if (ch == CH_SPACE || ch == CH_TAB) begin
				go_on = 1'b0;
			end else begin
				phase_eff = PH_INT;
				nxt.phase = PH_INT;
				if (ch == CH_MINUS) begin
					nxt.negative = 1'b1;
					go_on        = 1'b0;
				end else if (ch == CH_PLUS) begin
					go_on = 1'b0;
				end
			end
		end

		if (go_on) begin
			case (phase_eff)
				PH_INT: begin
					if (ch == CH_POINT) begin
						nxt.phase = PH_FRAC;
					end else if (is_digit) begin
						if (!cur.saturated) begin
							if (int_t > (INT_W+4)'(INT_MAX)) begin
								nxt.int_acc   = INT_MAX;
								nxt.saturated = 1'b1;
							end else begin
								nxt.int_acc = int_t[INT_W-1:0];
							end
						end
					end else begin
						nxt.phase = PH_DONE;
					end
				end
				PH_FRAC: begin
					if (is_digit) begin
						// drop digits past the last weighted place
						if (cur.frac_digits < DIGIT_CNT_W'(MAX_FRAC_DIGITS)) begin
							nxt.frac_digits = cur.frac_digits + 1'b1;
							nxt.frac_acc    = cur.frac_acc + frac_term[FRAC_BITS-1:0];
						end
					end else begin
						nxt.phase = PH_DONE;
					end
				end
				default: begin
					nxt = nxt;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== rtl/decimal_text_to_fixed_point.sv =====
// Converts ASCII decimal text, one character per transaction, to signed Q31.32.
// Depends on dtfx_pkg and dtfx_char_step.
//
// Usage:
//   The slave side takes one character per transaction: s_tdata is the ASCII
//   byte, s_tlast marks the final character of the string. Leading spaces and
//   tabs are skipped, one optional sign is taken, then integer digits and,
//   after a '.', fraction digits; any other character ends the number and the
//   rest of the string is ignored. On the s_tlast character the master side
//   presents one transaction: m_tdata holds the two's complement fixed-point
//   value, m_tuser is set when the integer part saturated at 2^31-1.
//   Characters without s_tlast produce nothing on the master side.
// Timing:
//   One character is accepted every cycle while s_tready is high. A result
//   appears on the master side after its last character is accepted: the input
//   register feeds the next-state logic, which loads the result register.
//   While the receiver stalls, characters keep flowing until a string end
//   reaches the input register with the result register still full; then
//   s_tready drops until the result is taken.
// Reset:
//   arst_n clears the parse state, the input register valid and the result valid.
`default_nettype none

module decimal_text_to_fixed_point
	import dtfx_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] ch
	input  wire logic               s_tlast,   // last
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [VALUE_W-1:0]      m_tdata,   // [63:0] value
	output logic                    m_tuser    // [0] overflow
);

	logic               valid_s1;
	logic [7:0]         ch_s1;
	logic               last_s1;
	parse_state_t       state_q;
	parse_state_t       state_nxt;
	logic               out_free;
	logic               advance;
	logic [VALUE_W-1:0] mag;
	logic [VALUE_W-1:0] value_q;
	logic               ovf_q;
	logic               out_valid_q;

	dtfx_char_step u_step (
		.ch  (ch_s1),
		.cur (state_q),
		.nxt (state_nxt)
	);

	assign out_free = !out_valid_q || m_tready;
	// a string end needs room in the result register; other characters never wait
	assign advance  = valid_s1 && (!last_s1 || out_free);
	assign s_tready = !valid_s1 || advance;

	assign mag = VALUE_W'({state_nxt.int_acc, state_nxt.frac_acc});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			ch_s1   <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PARSE_CLEAR;
		end else if (advance) begin
			state_q <= last_s1 ? PARSE_CLEAR : state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			value_q <= state_nxt.negative ? (VALUE_W'(0) - mag) : mag;
			ovf_q   <= state_nxt.saturated;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = value_q;
	assign m_tuser  = ovf_q;

endmodule

`default_nettype wire

// ===== bench/fixed_point_result_checker.sv =====
// Watches both streams of decimal_text_to_fixed_point, predicts each Q31.32 number
// from the accepted characters and compares it with the result transaction.
// Depends on dtfx_pkg for widths, parse phases and character codes.

module fixed_point_result_checker
	import dtfx_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	input  wire logic               s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] ch
	input  wire logic               s_tlast,   // last
	input  wire logic               m_tvalid,
	input  wire logic               m_tready,
	input  wire logic [VALUE_W-1:0] m_tdata,   // [63:0] value
	input  wire logic               m_tuser,   // [0] overflow
	output int                      results_due,
	output int                      mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               overflow;
	} fixed_number_t;

	fixed_number_t predicted_numbers [$];
	fixed_number_t want;

	// parser state of the model
	logic [1:0]             phase;
	logic                   negative;
	logic [INT_W-1:0]       int_acc;
	logic [FRAC_BITS+1:0]   frac_acc;
	logic [DIGIT_CNT_W-1:0] frac_digits;
	logic                   saturated;

	logic [FRAC_BITS+1:0]   digit_weight [1:MAX_FRAC_DIGITS];

	// floor(2^FRAC_BITS / 10^k)
	initial begin
		logic [63:0] power;
		power = 64'd1;
		for (int k = 1; k <= MAX_FRAC_DIGITS; k++) begin
			power = power * 64'd10;
			digit_weight[k] = (FRAC_BITS+2)'((64'd1 << FRAC_BITS) / power);
		end
	end

	task clear_parse;
		phase       = PH_SKIP;
		negative    = 1'b0;
		int_acc     = '0;
		frac_acc    = '0;
		frac_digits = '0;
		saturated   = 1'b0;
	endtask

	task parse_char(input logic [7:0] c);
		logic        is_digit;
		logic [3:0]  d;
		logic [63:0] grown;
		is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
		d = is_digit ? 4'(c - CH_ZERO) : 4'd0;
		if (phase == PH_SKIP) begin
			if (c == CH_SPACE || c == CH_TAB)
				return;
			phase = PH_INT;
			if (c == CH_MINUS) begin
				negative = 1'b1;
				return;
			end
			if (c == CH_PLUS)
				return;
		end
		if (phase == PH_INT) begin
			if (c == CH_POINT) begin
				phase = PH_FRAC;
			end else if (is_digit) begin
				if (!saturated) begin
					grown = 64'(int_acc) * 64'd10 + 64'(d);
					if (grown > 64'(INT_MAX)) begin
						int_acc   = INT_MAX;
						saturated = 1'b1;
					end else begin
						int_acc = INT_W'(grown);
					end
				end
			end else begin
				phase = PH_DONE;
			end
		end else if (phase == PH_FRAC) begin
			if (is_digit) begin
				// digits past the last weight add nothing
				if (frac_digits < MAX_FRAC_DIGITS) begin
					frac_digits = frac_digits + 1'b1;
					frac_acc = frac_acc + (FRAC_BITS+2)'(d) * digit_weight[frac_digits];
				end
			end else begin
				phase = PH_DONE;
			end
		end
	endtask

	function fixed_number_t current_number();
		logic [VALUE_W-1:0] mag;
		fixed_number_t      num;
		mag = (VALUE_W'(int_acc) << FRAC_BITS) | VALUE_W'(frac_acc);
		num.value    = negative ? -mag : mag;
		num.overflow = saturated;
		return num;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_parse();
			predicted_numbers.delete();
			results_due <= 0;
		end else begin
			// results first: a character taken this edge cannot have produced one yet
			if (m_tvalid && m_tready) begin
				if (predicted_numbers.size() == 0) begin
					$error("unexpected result: value %h overflow %b", m_tdata, m_tuser);
					mismatch_count++;
				end else begin
					want = predicted_numbers.pop_front();
					if (m_tdata !== want.value) begin
						$error("value: expected %h, actual %h", want.value, m_tdata);
						mismatch_count++;
					end
					if (m_tuser !== want.overflow) begin
						$error("overflow: expected %b, actual %b", want.overflow, m_tuser);
						mismatch_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				parse_char(s_tdata);
				if (s_tlast) begin
					predicted_numbers.push_back(current_number());
					clear_parse();
				end
			end
			results_due <= predicted_numbers.size();
		end
	end

endmodule

// ===== bench/tb_top.sv =====
// Top of the decimal_text_to_fixed_point regression: clock, reset, character
// stimulus, receiver back-pressure and the verdict.
// Depends on dtfx_pkg, the block and fixed_point_result_checker.

module tb_top;
	import dtfx_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;

	logic               clk;
	logic               arst_n   = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata  = 8'h00;
	logic               s_tlast  = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [VALUE_W-1:0] m_tdata;
	logic               m_tuser;

	int results_due;
	int mismatch_count;
	int cycle_count    = 0;
	int chars_sent     = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	bit hold_req       = 1'b0;

	logic [7:0] text_buf [$];

	decimal_text_to_fixed_point dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	fixed_point_result_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tlast        (s_tlast),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.results_due    (results_due),
		.mismatch_count (mismatch_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("decimal_text_to_fixed_point regression: fail");
			$finish;
		end
	end

	// receiver: random stalls, or one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	task load_text(input string s);
		text_buf.delete();
		for (int i = 0; i < s.len(); i++)
			text_buf.push_back(s[i]);
	endtask

	task send_text;
		for (int i = 0; i < text_buf.size(); i++) begin
			while ($urandom_range(0, 99) < send_idle_pct) begin
				s_tvalid <= 1'b0;
				s_tdata  <= 8'($urandom_range(0, 255));
				@(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= text_buf[i];
			s_tlast  <= (i == text_buf.size() - 1);
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			chars_sent++;
		end
	endtask

	task send_string(input string s);
		load_text(s);
		send_text();
	endtask

	// mostly well-formed numbers with random content, some noise and damage
	task build_random_text;
		int    shape;
		int    n;
		string prefix;
		text_buf.delete();
		shape = $urandom_range(0, 99);
		if (shape < 12) begin
			repeat ($urandom_range(1, 6))
				text_buf.push_back(8'($urandom_range(0, 255)));
		end else begin
			repeat ($urandom_range(0, 2))
				text_buf.push_back($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
			case ($urandom_range(0, 3))
				0: text_buf.push_back(CH_MINUS);
				1: text_buf.push_back(CH_PLUS);
				default: ;
			endcase
			if ($urandom_range(0, 15) == 0) begin
				// land right at the saturation threshold
				prefix = "214748364";
				for (int i = 0; i < prefix.len(); i++)
					text_buf.push_back(prefix[i]);
				text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end else begin
				shape = $urandom_range(0, 99);
				n = (shape < 10) ? 0 : (shape < 85) ? $urandom_range(1, 6) : $urandom_range(9, 12);
				repeat (n)
					text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 3) != 0) begin
				text_buf.push_back(CH_POINT);
				n = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 6) : $urandom_range(9, 13);
				repeat (n)
					text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
			end
			if ($urandom_range(0, 4) == 0) begin
				repeat ($urandom_range(1, 3))
					text_buf.push_back(8'($urandom_range(0, 255)));
			end
			if ($urandom_range(0, 9) == 0 && text_buf.size() > 0)
				text_buf[$urandom_range(0, text_buf.size() - 1)] = 8'($urandom_range(0, 255));
		end
		if (text_buf.size() == 0)
			text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
	endtask

	task run_random(input int char_budget);
		int start;
		start = chars_sent;
		while (chars_sent - start < char_budget) begin
			build_random_text();
			send_text();
		end
	endtask

	// drop valid, then hold until every predicted number has come out
	task wait_drained;
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_due != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 9;
		recv_idle_pct = 71;

		send_string("0");
		send_string("2147483647");
		send_string("2147483648");
		send_string("-99999999999.5");
		send_string("+3.25");
		send_string(" \t-0.0");
		send_string(" ");
		send_string("-");
		send_string("+");
		send_string(".");
		send_string("0.9999999999");
		send_string("1.234567890123");
		send_string("-2147483647.0000000001");
		send_string("12+3");
		send_string("--1");
		send_string("- 1");
		send_string("1.2.3");
		send_string("  42  ");
		load_text("5");
		text_buf.push_front(8'hff);
		send_text();
		load_text("7");
		text_buf.push_back(8'h80);
		text_buf.push_back("3");
		send_text();
		wait_drained();

		run_random(550);
		wait_drained();

		send_idle_pct = 71;
		recv_idle_pct = 9;
		run_random(550);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_req = 1'b1;
		run_random(500);
		wait_drained();

		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_due == 0)
			$display("decimal_text_to_fixed_point regression: pass");
		else
			$display("decimal_text_to_fixed_point regression: fail");
		$finish;
	end

endmodule
